FILE: sv/stepper_position_sequencer_defines.svh
// ---------------------------------------------------------------------------
// stepper_position_sequencer_defines.svh
// Assertion macros shared by the stepper position sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef STEPPER_POSITION_SEQUENCER_DEFINES_SVH
`define STEPPER_POSITION_SEQUENCER_DEFINES_SVH

// check cons on the same edge whenever ante holds
`define SPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons on the edge after ante holds
`define SPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sps_pkg.sv
// ---------------------------------------------------------------------------
// sps_pkg
// Types, codes and sizes of the stepper position sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    localparam int PHASE_STEPS   = 4;
    localparam int POSITION_BITS = 16;
    localparam int PHASE_BITS    = $clog2(PHASE_STEPS);
    localparam int CMP_BITS      = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(PHASE_STEPS - 1);
    localparam logic [7:0]            IDLE_LEVEL = 8'hFF;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAX_TARGET     = 3'd0,
        CFG_BACKLASH_STEPS = 3'd1,
        CFG_DUTY_VALUE     = 3'd2,
        CFG_PHASE_TABLE    = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic [14:0] max_target;
        logic [15:0] backlash_steps;
        logic [7:0]  duty_value;
        logic [15:0] phase_table;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         coil_a;
        logic [7:0]         coil_b;
        logic [7:0]         coil_c;
        logic [7:0]         coil_d;
        logic               out_of_bounds;
        logic               is_idle;
        logic signed [15:0] position;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/stepper_position_sequencer.sv
// ---------------------------------------------------------------------------
// stepper_position_sequencer
// Full-step stepper sequencer with position counter and backlash steps.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_ready  homing, target
//   out      from block out_valid/out_ready  coil_a..coil_d, out_of_bounds,
//                                            is_idle, position
//   cfg      to block   cfg_we               cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; an accepted item
// passes through the input register and then the result register.
// The motion state advances when an item moves from the input register
// into the result register.
// A stalled result holds both registers; input stays ready while either
// register is free. Reset clears state and configuration to defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module stepper_position_sequencer
    import sps_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      homing,
    input  wire logic signed [15:0]        target,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     coil_a,
    output logic [7:0]                     coil_b,
    output logic [7:0]                     coil_c,
    output logic [7:0]                     coil_d,
    output logic                           out_of_bounds,
    output logic                           is_idle,
    output logic signed [15:0]             position,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t result;
    result_t result_reg;

    logic               in_valid_reg;
    logic               homing_reg;
    logic signed [15:0] target_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               fire;

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    sps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sps_step_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .homing (homing_reg),
        .target (target_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            homing_reg <= homing;
            target_reg <= target;
        end
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign coil_a        = result_reg.coil_a;
    assign coil_b        = result_reg.coil_b;
    assign coil_c        = result_reg.coil_c;
    assign coil_d        = result_reg.coil_d;
    assign out_of_bounds = result_reg.out_of_bounds;
    assign is_idle       = result_reg.is_idle;
    assign position      = result_reg.position;

endmodule

`default_nettype wire

FILE: sv/sps_cfg_regs.sv
// ---------------------------------------------------------------------------
// sps_cfg_regs
// Configuration registers, written through a plain index/data port.
// ---------------------------------------------------------------------------
`default_nettype none

module sps_cfg_regs
    import sps_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_target     <= 15'h7FFF;
            cfg_reg.backlash_steps <= 16'h0000;
            cfg_reg.duty_value     <= 8'hFF;
            cfg_reg.phase_table    <= 16'h8421;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_TARGET:     cfg_reg.max_target     <= cfg_data[14:0];
                CFG_BACKLASH_STEPS: cfg_reg.backlash_steps <= cfg_data;
                CFG_DUTY_VALUE:     cfg_reg.duty_value     <= cfg_data[7:0];
                CFG_PHASE_TABLE:    cfg_reg.phase_table    <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/sps_step_core.sv
// ---------------------------------------------------------------------------
// sps_step_core
// Motion state and the per-item decision: home, flag, backlash, step, idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stepper_position_sequencer_defines.svh"

module sps_step_core
    import sps_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               fire,
    input  wire logic               homing,
    input  wire logic signed [15:0] target,
    output result_t                 result
);

    logic [POSITION_BITS-1:0] cur_position_reg;
    logic [POSITION_BITS-1:0] cur_position_next;
    logic                     move_dir_negative_reg;
    logic                     move_dir_negative_next;
    logic [PHASE_BITS-1:0]    phase_index_reg;
    logic [PHASE_BITS-1:0]    phase_index_next;
    logic [15:0]              backlash_left_reg;
    logic [15:0]              backlash_left_next;

    logic signed [CMP_BITS-1:0] pos_ext;
    logic signed [CMP_BITS-1:0] tgt_ext;
    logic signed [CMP_BITS-1:0] pos_next_ext;
    logic                       oob;
    logic                       step_en;
    logic                       move_en;
    logic                       step_neg;
    logic [3:0]                 row;

    assign pos_ext = CMP_BITS'($signed(cur_position_reg));
    assign tgt_ext = CMP_BITS'(target);
    assign oob     = target > $signed({1'b0, cfg.max_target});
    assign row     = cfg.phase_table[4 * phase_index_reg[1:0] +: 4];

    always_comb
    begin
        step_en                = 1'b0;
        move_en                = 1'b0;
        move_dir_negative_next = move_dir_negative_reg;
        backlash_left_next     = backlash_left_reg;
        if (homing)
        begin
            step_en = 1'b1;
        end
        else if (!oob)
        begin
            if (pos_ext == tgt_ext)
            begin
                if (backlash_left_reg != 16'd0)
                begin
                    step_en            = 1'b1;
                    backlash_left_next = backlash_left_reg - 16'd1;
                end
            end
            else
            begin
                step_en                = 1'b1;
                move_en                = 1'b1;
                move_dir_negative_next = pos_ext > tgt_ext;
                if (move_dir_negative_next != move_dir_negative_reg)
                begin
                    backlash_left_next = cfg.backlash_steps;
                end
            end
        end
        step_neg = move_dir_negative_next;

        cur_position_next = cur_position_reg;
        if (move_en)
        begin
            cur_position_next = step_neg ? cur_position_reg - POSITION_BITS'(1)
                                         : cur_position_reg + POSITION_BITS'(1);
        end

        phase_index_next = phase_index_reg;
        if (step_en)
        begin
            if (step_neg)
            begin
                phase_index_next = (phase_index_reg == '0) ? PHASE_LAST
                                 : phase_index_reg - PHASE_BITS'(1);
            end
            else
            begin
                phase_index_next = (phase_index_reg == PHASE_LAST) ? '0
                                 : phase_index_reg + PHASE_BITS'(1);
            end
        end
    end

    assign pos_next_ext = CMP_BITS'($signed(cur_position_next));

    always_comb
    begin
        result.out_of_bounds = !homing && oob;
        result.is_idle       = !step_en;
        result.position      = pos_next_ext[15:0];
        if (step_en)
        begin
            result.coil_a = row[0] ? cfg.duty_value : 8'h00;
            result.coil_b = row[1] ? cfg.duty_value : 8'h00;
            result.coil_c = row[2] ? cfg.duty_value : 8'h00;
            result.coil_d = row[3] ? cfg.duty_value : 8'h00;
        end
        else
        begin
            result.coil_a = IDLE_LEVEL;
            result.coil_b = IDLE_LEVEL;
            result.coil_c = IDLE_LEVEL;
            result.coil_d = IDLE_LEVEL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_position_reg      <= '0;
            move_dir_negative_reg <= 1'b0;
            phase_index_reg       <= '0;
            backlash_left_reg     <= '0;
        end
        else if (fire)
        begin
            cur_position_reg      <= cur_position_next;
            move_dir_negative_reg <= move_dir_negative_next;
            phase_index_reg       <= phase_index_next;
            backlash_left_reg     <= backlash_left_next;
        end
    end

    `SPS_ASSERT_NEXT(a_step_advances_phase, clk, rst_n, fire && step_en,
        phase_index_reg != $past(phase_index_reg), "step did not advance phase")
    `SPS_ASSERT_NEXT(a_homing_holds_position, clk, rst_n, fire && homing,
        cur_position_reg == $past(cur_position_reg), "homing moved position")
    `SPS_ASSERT_SAME(a_oob_is_idle, clk, rst_n, result.out_of_bounds,
        result.is_idle && !move_en, "out of bounds item did not idle")

endmodule

`default_nettype wire
